// ===== rtl/core/frcs_pkg.sv =====
// frcs_pkg: shared types, constants and helpers of the filtered random cell sampler
// used by filtered_random_cell_sampler_top and frcs_checker; depends on nothing
package frcs_pkg;

	localparam int NUM_ORBS_DEF  = 5;
	localparam int MAX_CELLS_DEF = 4096;

	localparam int          CELL_INDEX_W = 12;
	localparam int          SEED_W       = 32;
	localparam logic [31:0] SEED_RESET   = 32'hDEADBEEF;

	// xorshift32 shift amounts
	localparam int XS_SHIFT_A = 13;
	localparam int XS_SHIFT_B = 17;
	localparam int XS_SHIFT_C = 5;

	localparam logic KIND_ORB    = 1'b0;
	localparam logic KIND_PORTAL = 1'b1;

	typedef struct packed {
		logic is_water;
		logic is_border;
		logic last_cell;
	} in_word_t;

	typedef struct packed {
		logic [CELL_INDEX_W-1:0] cell_index;
		logic                    pick_kind;
		logic                    found;
		logic                    last_pick;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAND,
		ST_MOD,
		ST_RD_I,
		ST_RD_J,
		ST_SWAP,
		ST_PORTAL,
		ST_EMPTY
	} state_t;

	function automatic logic [SEED_W-1:0] seed_value(input logic [SEED_W-1:0] s);
		seed_value = (s == '0) ? SEED_W'(1) : s;
	endfunction

	function automatic logic [SEED_W-1:0] xorshift32(input logic [SEED_W-1:0] s);
		logic [SEED_W-1:0] x;
		x = s;
		x = x ^ (x << XS_SHIFT_A);
		x = x ^ (x >> XS_SHIFT_B);
		x = x ^ (x << XS_SHIFT_C);
		xorshift32 = x;
	endfunction

endpackage

// ===== rtl/core/frcs_ram.sv =====
// frcs_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
module frcs_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/filtered_random_cell_sampler_top.sv =====
// filtered_random_cell_sampler_top: land list, xorshift32 draw and partial shuffle
// depends on frcs_pkg and frcs_ram
//
// Cells stream in at one word per cycle while idle; each cell that is neither water
// nor border has its position appended to a list ram. The word flagged last_cell
// starts the draw: up to NUM_ORBS+1 shuffle steps, each made of one xorshift32 step,
// a bit-serial modulo by the remaining count, two list reads and a swap write on the
// single ram port pair. Each step emits one orb word, or the portal word on the last
// step; if land is short the portal word (slot 0) follows in a state of its own.
// A set with no land yields one word with found low. New cells are refused during
// the draw; a pending output word never blocks cell loading. No clearing pass.
module filtered_random_cell_sampler_top #(
	parameter int NUM_ORBS  = frcs_pkg::NUM_ORBS_DEF,
	parameter int MAX_CELLS = frcs_pkg::MAX_CELLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [frcs_pkg::SEED_W-1:0]      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  frcs_pkg::in_word_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output frcs_pkg::out_word_t              out_data
);

	localparam int IDX_W   = $clog2(MAX_CELLS);
	localparam int CNT_W   = $clog2(MAX_CELLS + 1);
	localparam int PICK_W  = $clog2(NUM_ORBS + 2);
	localparam int CMP_W   = (CNT_W > PICK_W) ? CNT_W : PICK_W;
	localparam int SEED_W  = frcs_pkg::SEED_W;
	localparam int STEP_W  = $clog2(SEED_W);
	localparam int CI_W    = frcs_pkg::CELL_INDEX_W;

	frcs_pkg::state_t state_q, state_nxt;

	logic [SEED_W-1:0] seed_q;
	logic [SEED_W-1:0] rand_q;
	logic [SEED_W-1:0] div_q;
	logic [CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  land_count_q;
	logic [PICK_W-1:0] pick_q;
	logic [IDX_W-1:0]  data_i_q;
	logic [IDX_W-1:0]  pick0_q;
	logic              out_valid_q;
	frcs_pkg::out_word_t out_data_q;

	logic              in_acc;
	logic              eligible;
	logic [CNT_W-1:0]  land_count_nxt;
	logic [CNT_W-1:0]  modulus;
	logic [CNT_W:0]    rem_shift;
	logic              rem_ge;
	logic [CNT_W-1:0]  rem_nxt;
	logic [CMP_W:0]    j_sum;
	logic [IDX_W-1:0]  i_idx;
	logic [IDX_W-1:0]  j_idx;
	logic              more_picks;
	logic              pick_is_portal;
	logic              out_free;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [IDX_W-1:0]  ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [IDX_W-1:0]  ram_rdata;

	logic              out_load;
	frcs_pkg::out_word_t out_nxt;
	logic              pick_adv;
	logic              set_done;

	// list entries zero-extended or truncated to the output field
	function automatic logic [CI_W-1:0] to_cell_index(input logic [IDX_W-1:0] v);
		logic [IDX_W+CI_W-1:0] ext;
		ext = {{CI_W{1'b0}}, v};
		to_cell_index = ext[CI_W-1:0];
	endfunction

	assign in_ready = (state_q == frcs_pkg::ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign eligible = !in_data.is_water && !in_data.is_border
		&& (pos_q < CNT_W'(MAX_CELLS));
	assign land_count_nxt = land_count_q + CNT_W'(eligible);

	// remaining count n - i, nonzero while a step runs
	assign modulus   = CNT_W'(CMP_W'(land_count_q) - CMP_W'(pick_q));
	assign rem_shift = {rem_q, div_q[SEED_W-1]};
	assign rem_ge    = rem_shift >= {1'b0, modulus};
	assign rem_nxt   = rem_ge ? CNT_W'(rem_shift - {1'b0, modulus}) : CNT_W'(rem_shift);

	assign j_sum = (CMP_W+1)'(CMP_W'(pick_q)) + (CMP_W+1)'(CMP_W'(rem_q));
	assign j_idx = j_sum[IDX_W-1:0];
	assign i_idx = IDX_W'(CMP_W'(pick_q));

	assign more_picks     = (CMP_W'(pick_q) + CMP_W'(1)) < CMP_W'(land_count_q);
	assign pick_is_portal = (pick_q == PICK_W'(NUM_ORBS));

	always_comb begin
		state_nxt = state_q;
		ram_we    = 1'b0;
		ram_waddr = land_count_q[IDX_W-1:0];
		ram_wdata = pos_q[IDX_W-1:0];
		ram_raddr = (state_q == frcs_pkg::ST_RD_I) ? i_idx : j_idx;
		out_load  = 1'b0;
		out_nxt   = '0;
		pick_adv  = 1'b0;
		set_done  = 1'b0;
		case (state_q)
			frcs_pkg::ST_IDLE: begin
				if (in_acc) begin
					ram_we = eligible;
					if (in_data.last_cell) begin
						state_nxt = (land_count_nxt == '0) ? frcs_pkg::ST_EMPTY
							: frcs_pkg::ST_RAND;
					end
				end
			end
			frcs_pkg::ST_RAND: begin
				state_nxt = frcs_pkg::ST_MOD;
			end
			frcs_pkg::ST_MOD: begin
				if (step_q == STEP_W'(SEED_W - 1)) begin
					state_nxt = frcs_pkg::ST_RD_I;
				end
			end
			frcs_pkg::ST_RD_I: begin
				state_nxt = frcs_pkg::ST_RD_J;
			end
			frcs_pkg::ST_RD_J: begin
				state_nxt = frcs_pkg::ST_SWAP;
			end
			frcs_pkg::ST_SWAP: begin
				// slot i is final now; only slot j needs the old slot i word
				if (out_free) begin
					ram_we              = 1'b1;
					ram_waddr           = j_idx;
					ram_wdata           = data_i_q;
					out_load            = 1'b1;
					out_nxt.cell_index  = to_cell_index(ram_rdata);
					out_nxt.pick_kind   = pick_is_portal ? frcs_pkg::KIND_PORTAL
						: frcs_pkg::KIND_ORB;
					out_nxt.found       = 1'b1;
					out_nxt.last_pick   = pick_is_portal;
					pick_adv            = 1'b1;
					if (pick_is_portal) begin
						state_nxt = frcs_pkg::ST_IDLE;
						set_done  = 1'b1;
					end else if (more_picks) begin
						state_nxt = frcs_pkg::ST_RAND;
					end else begin
						state_nxt = frcs_pkg::ST_PORTAL;
					end
				end
			end
			frcs_pkg::ST_PORTAL: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_nxt.cell_index = to_cell_index(pick0_q);
					out_nxt.pick_kind  = frcs_pkg::KIND_PORTAL;
					out_nxt.found      = 1'b1;
					out_nxt.last_pick  = 1'b1;
					state_nxt          = frcs_pkg::ST_IDLE;
					set_done           = 1'b1;
				end
			end
			frcs_pkg::ST_EMPTY: begin
				if (out_free) begin
					out_load           = 1'b1;
					out_nxt.cell_index = '0;
					out_nxt.pick_kind  = frcs_pkg::KIND_PORTAL;
					out_nxt.found      = 1'b0;
					out_nxt.last_pick  = 1'b1;
					state_nxt          = frcs_pkg::ST_IDLE;
					set_done           = 1'b1;
				end
			end
			default: begin
				state_nxt = frcs_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frcs_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= frcs_pkg::SEED_RESET;
			rand_q       <= frcs_pkg::seed_value(frcs_pkg::SEED_RESET);
			pos_q        <= '0;
			land_count_q <= '0;
			pick_q       <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_data;
			end
			if (in_acc) begin
				// first cell of a set reloads the generator
				if (pos_q == '0) begin
					rand_q <= frcs_pkg::seed_value(seed_q);
				end
				if (pos_q < CNT_W'(MAX_CELLS)) begin
					pos_q <= pos_q + CNT_W'(1);
				end
				land_count_q <= land_count_nxt;
				pick_q       <= '0;
			end
			if (state_q == frcs_pkg::ST_RAND) begin
				rand_q <= frcs_pkg::xorshift32(rand_q);
				step_q <= '0;
			end
			if (state_q == frcs_pkg::ST_MOD) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (pick_adv) begin
				pick_q <= pick_q + PICK_W'(1);
			end
			if (set_done) begin
				pos_q        <= '0;
				land_count_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == frcs_pkg::ST_RAND) begin
			div_q <= frcs_pkg::xorshift32(rand_q);
			rem_q <= '0;
		end
		if (state_q == frcs_pkg::ST_MOD) begin
			div_q <= div_q << 1;
			rem_q <= rem_nxt;
		end
		if (state_q == frcs_pkg::ST_RD_J) begin
			data_i_q <= ram_rdata;
		end
		if (pick_adv && (pick_q == '0)) begin
			pick0_q <= ram_rdata;
		end
		if (out_load) begin
			out_data_q <= out_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	frcs_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_CELLS)
	) u_land_list (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// ===== rtl/core/frcs_checker.sv =====
// frcs_checker: port-level checks of the cell sampler, bound to the top level
// depends on frcs_pkg and filtered_random_cell_sampler_top
module frcs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_ready,
	input frcs_pkg::out_word_t         out_data
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// a word with found low is a closing portal word with cell index 0
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.last_pick
			&& (out_data.pick_kind == frcs_pkg::KIND_PORTAL)
			&& (out_data.cell_index == '0))
		else $error("not-found word malformed");

	// the portal word and only it closes a draw
	a_portal_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.pick_kind == frcs_pkg::KIND_PORTAL) |-> out_data.last_pick)
		else $error("portal word not marked last");

	a_orb_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.pick_kind == frcs_pkg::KIND_ORB)
			|-> !out_data.last_pick && out_data.found)
		else $error("orb word marked last or not found");

endmodule

bind filtered_random_cell_sampler_top frcs_checker u_frcs_checker (.*);
